// ===== sv/pdsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Proper divisor sum package
// Shared constants and the sequencer state type for the aliquot sum unit.
// ----------------------------------------------------------------------------
package pdsp_pkg;

    // The divisor sum field is fixed at 36 bits and saturates at its maximum.
    localparam int unsigned SUM_WIDTH = 36;
    localparam logic [SUM_WIDTH-1:0] SUM_MAX = {SUM_WIDTH{1'b1}};

    // The result item's tdata is the divisor sum padded to whole bytes.
    localparam int unsigned OUT_TDATA_WIDTH = ((SUM_WIDTH + 7) / 8) * 8;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_DIV,
        S_ADD_D,
        S_ADD_Q,
        S_NEXT,
        S_ONE,
        S_ROOT
    } t_state;

    // The result item waits in the idle state until it is taken.
    localparam t_state S_OUT_FIRST = S_IDLE;

endpackage : pdsp_pkg
`default_nettype wire

// ===== sv/pdsp_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shared restoring divider
// Divides the held number by the trial divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pdsp_divider #(
    parameter int unsigned NUMBER_WIDTH = 32,
    parameter int unsigned DIVISOR_WIDTH = 17
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_start,
    input  wire [NUMBER_WIDTH-1:0]   i_dividend,
    input  wire [DIVISOR_WIDTH-1:0]  i_divisor,
    output logic                     o_done,
    output logic [NUMBER_WIDTH-1:0]  o_quotient,
    output logic                     o_rem_zero
);

    localparam int unsigned CW = $clog2(NUMBER_WIDTH + 1);

    logic [NUMBER_WIDTH-1:0]  r_quo, n_quo;
    logic [DIVISOR_WIDTH-1:0] r_rem, n_rem;
    logic [DIVISOR_WIDTH-1:0] r_div, n_div;
    logic [CW-1:0]            r_cnt, n_cnt;
    logic                     r_busy, n_busy;
    logic                     r_done, n_done;

    logic [DIVISOR_WIDTH:0]   rem_shift;
    logic [DIVISOR_WIDTH:0]   diff;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb begin
        rem_shift = {r_rem, r_quo[NUMBER_WIDTH-1]};
        diff      = rem_shift - {1'b0, r_div};
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_div     = r_div;
        n_cnt     = r_cnt;
        n_busy    = r_busy;
        n_done    = 1'b0;
        if (i_start) begin
            n_quo  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
            n_cnt  = CW'(NUMBER_WIDTH);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (rem_shift >= {1'b0, r_div}) begin
                n_rem = diff[DIVISOR_WIDTH-1:0];
                n_quo = {r_quo[NUMBER_WIDTH-2:0], 1'b1};
            end else begin
                n_rem = rem_shift[DIVISOR_WIDTH-1:0];
                n_quo = {r_quo[NUMBER_WIDTH-2:0], 1'b0};
            end
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state is cleared by reset; the datapath needs none.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
    assign o_rem_zero = (r_rem == '0);

endmodule : pdsp_divider
`default_nettype wire

// ===== sv/proper_divisor_sum_perfect_test_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Proper divisor sum and perfect number test
// Sums the proper divisors of a number by the paired-divisor method.
// ----------------------------------------------------------------------------
// The unit takes one number per item and returns its aliquot sum and a flag
// that is set when the number is perfect. Every trial divisor d with d*d below
// the number goes through a shared restoring divider that produces one
// quotient bit per cycle; when d divides the number, both d and the quotient
// are added to the sum. The numbers 0 and 1 skip the trials and return a
// zero sum. The unit is busy from the accepted item until its result item is
// taken at the output.
// ----------------------------------------------------------------------------
module proper_divisor_sum_perfect_test_unit #(
    parameter int unsigned NUMBER_WIDTH = 32
) (
    input  wire                                        i_clk,
    input  wire                                        i_rst_n,
    // Input item: number, zero padded to whole bytes.
    input  wire                                        s_axis_tvalid,
    output logic                                       s_axis_tready,
    input  wire [((NUMBER_WIDTH+7)/8)*8-1:0]           s_axis_tdata,
    // Result item: divisor_sum in tdata, zero padded; is_perfect in tuser.
    output logic                                       m_axis_tvalid,
    input  wire                                        m_axis_tready,
    output logic [pdsp_pkg::OUT_TDATA_WIDTH-1:0]       m_axis_tdata,
    output logic                                       m_axis_tuser
);

    localparam int unsigned DW  = (NUMBER_WIDTH + 1) / 2 + 1;
    localparam int unsigned SQW = NUMBER_WIDTH + 2;
    localparam int unsigned SW  = pdsp_pkg::SUM_WIDTH;
    localparam int unsigned AW  = ((NUMBER_WIDTH > SW) ? NUMBER_WIDTH : SW) + 1;

    pdsp_pkg::t_state          r_state, n_state;
    logic                      r_out_valid, n_out_valid;
    logic [NUMBER_WIDTH-1:0]   r_number, n_number;
    logic [DW-1:0]             r_trial, n_trial;
    logic [SQW-1:0]            r_square, n_square;
    logic [SW-1:0]             r_total, n_total;

    logic                      div_start;
    logic                      div_done;
    logic [NUMBER_WIDTH-1:0]   div_quo;
    logic                      div_rem_zero;

    logic [AW-1:0]             add_op;
    logic [AW-1:0]             add_sum;
    logic [SW-1:0]             sat_total;
    logic                      is_perfect;

    // Shared divider for every trial divisor.
    pdsp_divider #(
        .NUMBER_WIDTH  (NUMBER_WIDTH),
        .DIVISOR_WIDTH (DW)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_number),
        .i_divisor  (r_trial),
        .o_done     (div_done),
        .o_quotient (div_quo),
        .o_rem_zero (div_rem_zero)
    );

    // Saturating accumulator operand, chosen by the sequencer state.
    always_comb begin
        case (r_state)
            pdsp_pkg::S_ADD_D: add_op = AW'(r_trial);
            pdsp_pkg::S_ADD_Q: add_op = AW'(div_quo);
            pdsp_pkg::S_ONE:   add_op = AW'(1);
            pdsp_pkg::S_ROOT:  add_op = AW'(r_trial);
            default:           add_op = '0;
        endcase
        add_sum   = AW'(r_total) + add_op;
        sat_total = (add_sum > AW'(pdsp_pkg::SUM_MAX)) ? pdsp_pkg::SUM_MAX
                                                       : add_sum[SW-1:0];
    end

    // Sequencer: next state and datapath updates.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_number    = r_number;
        n_trial     = r_trial;
        n_square    = r_square;
        n_total     = r_total;
        div_start   = 1'b0;
        case (r_state)
            pdsp_pkg::S_IDLE: begin
                if (r_out_valid) begin
                    if (m_axis_tready) begin
                        n_out_valid = 1'b0;
                    end
                end else if (s_axis_tvalid) begin
                    n_number = s_axis_tdata[NUMBER_WIDTH-1:0];
                    n_trial  = DW'(2);
                    n_square = SQW'(4);
                    n_total  = '0;
                    n_state  = pdsp_pkg::S_TEST;
                end
            end
            pdsp_pkg::S_TEST: begin
                if (r_number <= NUMBER_WIDTH'(1)) begin
                    n_out_valid = 1'b1;
                    n_state     = pdsp_pkg::S_OUT_FIRST;
                end else if (r_square < SQW'(r_number)) begin
                    div_start = 1'b1;
                    n_state   = pdsp_pkg::S_DIV;
                end else begin
                    n_state = pdsp_pkg::S_ONE;
                end
            end
            pdsp_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = div_rem_zero ? pdsp_pkg::S_ADD_D : pdsp_pkg::S_NEXT;
                end
            end
            pdsp_pkg::S_ADD_D: begin
                n_total = sat_total;
                n_state = pdsp_pkg::S_ADD_Q;
            end
            pdsp_pkg::S_ADD_Q: begin
                n_total = sat_total;
                n_state = pdsp_pkg::S_NEXT;
            end
            pdsp_pkg::S_NEXT: begin
                // (d+1)^2 = d^2 + 2d + 1
                n_square = r_square + SQW'({r_trial, 1'b1});
                n_trial  = r_trial + DW'(1);
                n_state  = pdsp_pkg::S_TEST;
            end
            pdsp_pkg::S_ONE: begin
                n_total = sat_total;
                if (r_square == SQW'(r_number)) begin
                    n_state = pdsp_pkg::S_ROOT;
                end else begin
                    n_out_valid = 1'b1;
                    n_state     = pdsp_pkg::S_OUT_FIRST;
                end
            end
            pdsp_pkg::S_ROOT: begin
                n_total     = sat_total;
                n_out_valid = 1'b1;
                n_state     = pdsp_pkg::S_OUT_FIRST;
            end
            default: begin
                n_state = pdsp_pkg::S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pdsp_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_number <= n_number;
        r_trial  <= n_trial;
        r_square <= n_square;
        r_total  <= n_total;
    end

    // The number is perfect when it is nonzero and equals its divisor sum.
    assign is_perfect = (r_number != '0) && (AW'(r_number) == AW'(r_total));

    assign s_axis_tready = (r_state == pdsp_pkg::S_IDLE) && !r_out_valid;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = pdsp_pkg::OUT_TDATA_WIDTH'(r_total);
    assign m_axis_tuser  = is_perfect;

endmodule : proper_divisor_sum_perfect_test_unit
`default_nettype wire

// ===== sv/pdsp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Proper divisor sum port checker
// Watches the ports of the top level and checks its item ordering.
// ----------------------------------------------------------------------------
module pdsp_checker #(
    parameter int unsigned NUMBER_WIDTH = 32
) (
    input wire                                  i_clk,
    input wire                                  i_rst_n,
    input wire                                  s_axis_tvalid,
    input wire                                  s_axis_tready,
    input wire [((NUMBER_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    input wire                                  m_axis_tvalid,
    input wire                                  m_axis_tready,
    input wire [pdsp_pkg::OUT_TDATA_WIDTH-1:0]  m_axis_tdata,
    input wire                                  m_axis_tuser
);

    // The unit never takes an item while a result item is pending.
    a_busy_when_holding : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result item is pending");

    // After an item is taken the unit is busy in the next cycle.
    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && s_axis_tvalid && s_axis_tready) |=> !s_axis_tready && !m_axis_tvalid)
        else $error("unit not busy after taking an item");

    // Exactly one result per item: valid drops after the result is taken.
    a_single_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
        else $error("result item repeated");

    // A stalled result item holds its payload.
    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && m_axis_tvalid && !m_axis_tready) |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result item changed");

    // A perfect number always has a nonzero divisor sum.
    a_perfect_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata != '0))
        else $error("perfect flag with zero divisor sum");

endmodule : pdsp_checker

bind proper_divisor_sum_perfect_test_unit pdsp_checker #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
) u_pdsp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
